// ===== hdl/grm_pkg.sv =====
// Shared types and constants for the grid ray march block.
`default_nettype none
package grm_pkg;

  // Cell address span is fixed: 8 bits of column, 8 bits of row.
  localparam int unsigned CellBits = 8;
  localparam int unsigned AddrBits = 2 * CellBits;
  localparam int unsigned DistBits = 10;
  localparam logic [DistBits-1:0] DistMax = '1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RES_WALL  = 2'd0,
    RES_LEFT  = 2'd1,
    RES_LIMIT = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                cmd;
    logic [7:0]          cell_x;
    logic [7:0]          cell_y;
    logic                cell_solid;
    logic [15:0]         start_x;
    logic [15:0]         start_y;
    logic signed [15:0]  dir_x;
    logic signed [15:0]  dir_y;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [DistBits-1:0] distance;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture cast start point and direction
    logic wr;       // write one grid cell from the request
    logic clr;      // clear one cell of the sweep
    logic rd;       // read cell under current point
    logic step;     // advance point, count one step
    logic out_set;  // load result register
    res_e res;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_grid;
    logic solid;
    logic at_limit;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/grm_ctrl.sv =====
// Controller state machine for the grid ray march block.
`default_nettype none
module grm_ctrl
  import grm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_cast_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= RES_WALL;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_cast_i) state_d = S_READ;
      end
      S_READ: begin
        if (!stat_i.in_grid) begin
          res_d   = RES_LEFT;
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.solid) begin
          res_d   = RES_WALL;
          state_d = S_DONE;
        end else if (stat_i.at_limit) begin
          res_d   = RES_LIMIT;
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.res  = res_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: cmd_o.clr = 1'b1;
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i && in_cast_i;
        cmd_o.wr   = in_valid_i && !in_cast_i;
      end
      S_READ:  cmd_o.rd = stat_i.in_grid;
      S_CHECK: cmd_o.step = !stat_i.solid && !stat_i.at_limit;
      S_DONE:  cmd_o.out_set = stat_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/grm_dp.sv =====
// Datapath for the grid ray march block: grid memory, point, step counter, result.
`default_nettype none
module grm_dp
  import grm_pkg::*;
#(
  parameter int unsigned GRID_SIZE     = 256,
  parameter int unsigned MAX_STEPS     = 1023,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_req_t  in_req_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_stat_t      stat_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_rsp_t      out_rsp_o
);

  localparam int unsigned PosW  = DIR_FRAC_BITS + 12;
  localparam int unsigned IntW  = PosW - 1 - DIR_FRAC_BITS;
  localparam int unsigned StepW = $clog2(MAX_STEPS + 1);
  localparam int unsigned CntW  = (StepW > DistBits) ? StepW : DistBits;
  localparam logic [IntW-1:0]  GridLim  = IntW'(GRID_SIZE);
  localparam logic [StepW-1:0] StepLim  = StepW'(MAX_STEPS);
  localparam int unsigned      StartSh  = DIR_FRAC_BITS - 8;

  logic mem_q [2**AddrBits];

  logic [PosW-1:0]     pos_x_q, pos_y_q;
  logic signed [15:0]  dir_x_q, dir_y_q;
  logic [StepW-1:0]    cnt_q;
  logic [AddrBits-1:0] clr_q;
  logic                rd_bit_q, rd_oos_q;
  logic                out_valid_q;
  out_rsp_t            out_q;

  logic [IntW-1:0]     int_x, int_y;
  logic                in_x, in_y;
  logic [AddrBits-1:0] rd_addr, wr_addr;
  logic                wr_en, wr_bit, wr_ok;
  logic [CntW-1:0]     cnt_ext;
  logic [DistBits-1:0] dist_sat;

  assign int_x  = pos_x_q[PosW-2:DIR_FRAC_BITS];
  assign int_y  = pos_y_q[PosW-2:DIR_FRAC_BITS];
  assign in_x   = !pos_x_q[PosW-1] && (int_x < GridLim);
  assign in_y   = !pos_y_q[PosW-1] && (int_y < GridLim);
  assign rd_addr = {int_y[CellBits-1:0], int_x[CellBits-1:0]};

  assign wr_ok   = ({{(IntW-CellBits){1'b0}}, in_req_i.cell_x} < GridLim) &&
                   ({{(IntW-CellBits){1'b0}}, in_req_i.cell_y} < GridLim);
  assign wr_en   = cmd_i.clr || (cmd_i.wr && wr_ok);
  assign wr_addr = cmd_i.clr ? clr_q : {in_req_i.cell_y, in_req_i.cell_x};
  assign wr_bit  = cmd_i.clr ? 1'b0 : in_req_i.cell_solid;

  // Grid memory, one port: the controller never writes and reads together.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_bit;
    end else if (cmd_i.rd) begin
      rd_bit_q <= mem_q[rd_addr];
    end
  end

  // Cells with a coordinate beyond the address span always read empty.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_oos_q <= (|int_x[IntW-1:CellBits]) || (|int_y[IntW-1:CellBits]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= PosW'(in_req_i.start_x) << StartSh;
      pos_y_q <= PosW'(in_req_i.start_y) << StartSh;
      dir_x_q <= in_req_i.dir_x;
      dir_y_q <= in_req_i.dir_y;
    end else if (cmd_i.step) begin
      pos_x_q <= pos_x_q + {{(PosW-16){dir_x_q[15]}}, dir_x_q};
      pos_y_q <= pos_y_q + {{(PosW-16){dir_y_q[15]}}, dir_y_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) cnt_q <= '0;
      else if (cmd_i.step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.out_set) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign cnt_ext  = CntW'(cnt_q);
  assign dist_sat = (cnt_ext > CntW'(DistMax)) ? DistMax : cnt_ext[DistBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_set) begin
      out_q.status   <= cmd_i.res;
      out_q.distance <= (cmd_i.res == RES_WALL) ? dist_sat : '0;
    end
  end

  assign stat_o.in_grid  = in_x && in_y;
  assign stat_o.solid    = rd_bit_q && !rd_oos_q;
  assign stat_o.at_limit = cnt_q >= StepLim;
  assign stat_o.clr_last = &clr_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ===== hdl/grid_ray_march_distance.sv =====
// Top level of the grid ray march block: controller plus datapath.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ---------------------------------------
//  in       in   in_valid_i/in_stall_o  in_req_i  (write cell or cast request)
//  out      out  out_valid_o/out_stall_i out_rsp_o (status, distance)
//
// A write request gives no result. For a cast request, each step is one grid
// memory read (a read state that addresses the cell, then a check state on the
// registered read data). Up to MAX_STEPS steps. After reset the grid is swept
// to empty, one cell a cycle, with in_stall_o high. The result sits in an output
// register, so a new request is taken while the previous result waits under
// out_stall_i.
`default_nettype none
module grid_ray_march_distance
  import grm_pkg::*;
#(
  parameter int unsigned GRID_SIZE     = 256,
  parameter int unsigned MAX_STEPS     = 1023,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_rsp_t     out_rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: clear sweep, request intake, step sequencing, result hand-off.
  grm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cast_i  (in_req_i.cmd == CMD_CAST),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: grid memory, ray point, step counter, output register.
  grm_dp #(
    .GRID_SIZE     (GRID_SIZE),
    .MAX_STEPS     (MAX_STEPS),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== test/grm_checker.sv =====
// Channel monitor, cast predictor and result scoreboard for the grid ray march block.
`timescale 1ns / 1ps
module grm_checker
  import grm_pkg::*;
#(
  parameter int unsigned GRID_SIZE     = 256,
  parameter int unsigned MAX_STEPS     = 1023,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_stall_i,
  input  in_req_t  req_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_stall_i,
  input  out_rsp_t rsp_i,
  output int       fail_count_o,
  output int       in_flight_o
);

  localparam longint Span = longint'(1) << CellBits;

  bit       wall_map [1 << AddrBits];
  out_rsp_t cast_results_q [$];
  int       mismatches = 0;
  int       casts_in_flight = 0;

  assign fail_count_o = mismatches;
  assign in_flight_o  = casts_in_flight;

  function automatic bit on_grid(longint p);
    return p >= 0 && p < (longint'(GRID_SIZE) << DIR_FRAC_BITS);
  endfunction

  // cells past the 8-bit address span always read as empty
  function automatic bit wall_at(longint px, longint py);
    longint cx, cy;
    cx = px >>> DIR_FRAC_BITS;
    cy = py >>> DIR_FRAC_BITS;
    if (cx >= Span || cy >= Span) return 1'b0;
    return wall_map[AddrBits'(cy * Span + cx)];
  endfunction

  function automatic out_rsp_t march_ray(in_req_t r);
    longint      px, py, dx, dy;
    int unsigned steps;
    bit          done;
    out_rsp_t    res;
    px = longint'(r.start_x) << (DIR_FRAC_BITS - 8);
    py = longint'(r.start_y) << (DIR_FRAC_BITS - 8);
    dx = longint'($signed(r.dir_x));
    dy = longint'($signed(r.dir_y));
    steps        = 0;
    res.status   = RES_LEFT;
    res.distance = '0;
    done = !(on_grid(px) && on_grid(py));
    while (!done) begin
      if (wall_at(px, py)) begin
        res.status   = RES_WALL;
        res.distance = (steps > DistMax) ? DistMax : steps[DistBits-1:0];
        done = 1'b1;
      end else if (steps >= MAX_STEPS) begin
        res.status = RES_LIMIT;
        done = 1'b1;
      end else begin
        steps++;
        px += dx;
        py += dy;
        done = !(on_grid(px) && on_grid(py));
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      cast_results_q.delete();
      casts_in_flight <= 0;
    end else begin
      // a result can never belong to a request taken at the same edge
      if (rsp_valid_i && !rsp_stall_i) begin
        if (cast_results_q.size() == 0) begin
          $error("unexpected result: status %0d distance %0d", rsp_i.status, rsp_i.distance);
          mismatches++;
        end else begin
          want = cast_results_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_i.status);
            mismatches++;
          end
          if (rsp_i.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, rsp_i.distance);
            mismatches++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        if (req_i.cmd == CMD_WRITE) begin
          if (req_i.cell_x < GRID_SIZE && req_i.cell_y < GRID_SIZE)
            wall_map[{req_i.cell_y, req_i.cell_x}] = req_i.cell_solid;
        end else begin
          cast_results_q.push_back(march_ray(req_i));
        end
      end
      casts_in_flight <= cast_results_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Stimulus, reset, clock and verdict for the grid ray march block testbench.
`timescale 1ns / 1ps
module tb_top
  import grm_pkg::*;
;

  localparam int unsigned GridSize    = 256;
  localparam int unsigned MaxSteps    = 1023;
  localparam int unsigned DirFracBits = 14;

  // Random request count, directed part comes on top.
  localparam int NumRandom   = 700;
  // Leave room for a stray result after the last cast.
  localparam int DrainCycles = 2 * MaxSteps + 64;
  // Slowest legal run: clearing sweep, then every request a max-length cast
  // with worst stalls on both sides; taken four times over.
  localparam int CycleLimit  = 4 * (65536 + 1000 * (2 * MaxSteps + 64));
  localparam int LongHold    = 400;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     req_valid;
  logic     req_stall;
  in_req_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  out_rsp_t rsp;

  int fail_count;
  int in_flight;

  // stimulus knobs; idle_on and holds_asked are shared with the response-side stall process
  bit idle_on     = 1'b1;
  int holds_asked = 0;
  int reqs_sent   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_ray_march_distance #(
    .GRID_SIZE    (GridSize),
    .MAX_STEPS    (MaxSteps),
    .DIR_FRAC_BITS(DirFracBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp)
  );

  grm_checker #(
    .GRID_SIZE    (GridSize),
    .MAX_STEPS    (MaxSteps),
    .DIR_FRAC_BITS(DirFracBits)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_i (req_stall),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .in_flight_o (in_flight)
  );

  // Offer one request; returns right after the edge that accepted it.
  // Valid stays high afterwards so back-to-back requests see no bubble.
  task automatic send_req(input in_req_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    reqs_sent++;
  endtask

  // Write one cell; cast-only fields get random junk.
  task automatic put_cell(input logic [7:0] x, input logic [7:0] y, input logic solid);
    in_req_t r;
    r            = in_req_t'({$urandom, $urandom, $urandom});
    r.cmd        = CMD_WRITE;
    r.cell_x     = x;
    r.cell_y     = y;
    r.cell_solid = solid;
    send_req(r);
  endtask

  // Cast one ray; write-only fields get random junk.
  task automatic cast_ray(input logic [15:0] sx, input logic [15:0] sy,
                          input int dx, input int dy);
    in_req_t r;
    r         = in_req_t'({$urandom, $urandom, $urandom});
    r.cmd     = CMD_CAST;
    r.start_x = sx;
    r.start_y = sy;
    r.dir_x   = 16'(dx);
    r.dir_y   = 16'(dy);
    send_req(r);
  endtask

  // Drop valid so the last request is not taken again, then wait.
  // Sample in_flight only after an edge has passed: it is updated at the accepting edge.
  task automatic wait_all_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  function automatic int rand_dir();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Well-formed cast: drop a wall k steps down the ray path, then cast it.
  // Earlier walls on the path may still win; the checker sorts that out.
  task automatic aimed_cast();
    logic [15:0] sx, sy;
    int          dx, dy, k;
    longint      px, py, lim;
    sx  = 16'($urandom);
    sy  = 16'($urandom);
    dx  = rand_dir();
    dy  = rand_dir();
    k   = $urandom_range(0, 40);
    lim = longint'(GridSize) << DirFracBits;
    px  = (longint'(sx) << (DirFracBits - 8)) + longint'(k) * dx;
    py  = (longint'(sy) << (DirFracBits - 8)) + longint'(k) * dy;
    if (px >= 0 && px < lim && py >= 0 && py < lim)
      put_cell(8'(px >>> DirFracBits), 8'(py >>> DirFracBits), 1'b1);
    else
      put_cell(8'($urandom), 8'($urandom), 1'b1);
    // sometimes knock out a random cell too, which can break the aim
    if ($urandom_range(0, 3) == 0)
      put_cell(8'($urandom), 8'($urandom), 1'b0);
    cast_ray(sx, sy, dx, dy);
  endtask

  // Response side: random stall bursts, plus a long hold-off on request.
  initial begin : rsp_stall_gen
    int holds_done;
    holds_done = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        rsp_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int pick;
    rst_n     = 1'b0;
    req_valid = 1'b0;
    req       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing sweep after reset shows up as a long in_stall; send_req rides it out

    // ---- directed part ----
    // tiny x step (1/256 cell) from x=1/256: wall at column 4 is reached on
    // exactly the last allowed step, so the wall wins over the step limit
    put_cell(8'd4, 8'd0, 1'b1);
    cast_ray(16'h0001, 16'h0080, 64, 0);
    // move the wall one column out: same ray now runs out of steps
    put_cell(8'd4, 8'd0, 1'b0);
    put_cell(8'd5, 8'd0, 1'b1);
    cast_ray(16'h0001, 16'h0080, 64, 0);
    // starting on a wall: zero distance
    cast_ray(16'h0580, 16'h0080, 16384, 0);
    // unit steps along row 0 into the wall at column 5
    cast_ray(16'h0000, 16'h0080, 16384, 0);
    // zero direction never moves: step limit
    cast_ray(16'h2080, 16'h2080, 0, 0);
    // leaving below zero, by a whole cell and by one LSB
    cast_ray(16'h0080, 16'h0A80, -16384, 0);
    cast_ray(16'h0000, 16'h0000, -1, -1);
    // leaving past the top edge from the farthest start point
    cast_ray(16'hFFFF, 16'hFFFF, 16384, 16384);
    // diagonal into the far corner cell
    put_cell(8'd255, 8'd255, 1'b1);
    cast_ray(16'hF080, 16'hF080, 11585, 11585);
    // column 0 upward to the top-left corner cell
    put_cell(8'd0, 8'd255, 1'b1);
    cast_ray(16'h0080, 16'h0080, 0, 16384);
    // column 0 downward from just under that wall, leaves at the bottom
    cast_ray(16'h0080, 16'hFE80, 0, -16384);
    // row 0 leftward from the right edge back to column 5
    put_cell(8'd255, 8'd0, 1'b0);
    cast_ray(16'hFF80, 16'h0080, -16384, 0);
    // origin wall, hit at once, then cleared along with the far corner
    put_cell(8'd0, 8'd0, 1'b1);
    cast_ray(16'h0000, 16'h0000, 16384, 16384);
    put_cell(8'd0, 8'd0, 1'b0);
    put_cell(8'd255, 8'd255, 1'b0);

    // ---- random part ----
    while (reqs_sent < NumRandom + 25) begin
      // receiver holds off for a long stretch while casts keep coming
      if (holds_asked == 0 && reqs_sent >= 250) begin
        holds_asked++;
        repeat (8) aimed_cast();
      end
      // sender goes quiet until the block has drained
      if (reqs_sent >= 450 && reqs_sent < 454)
        wait_all_results();
      // last stretch runs with no idling on either side
      if (reqs_sent >= 600)
        idle_on = 1'b0;

      pick = $urandom_range(0, 99);
      if (pick < 60)
        aimed_cast();
      else if (pick < 80)
        put_cell(8'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 95)
        cast_ray(16'($urandom), 16'($urandom), rand_dir(), rand_dir());
      else
        // slow rays, many of them end on the step limit
        cast_ray(16'($urandom), 16'($urandom),
                 int'($urandom_range(0, 96)) - 48, int'($urandom_range(0, 96)) - 48);
    end

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
